// ===== design/ewswt_pkg.sv =====
`timescale 1ns / 1ps

package ewswt_pkg;

	localparam int PAGE_BYTES   = 8;
	localparam int DEVICE_BYTES = 256;
	localparam int NUM_PAGES    = (DEVICE_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;

	localparam int ADDR_W = 8;
	localparam int CNT_W  = 9;
	localparam int LEN_W  = 4;
	localparam int CTR_W  = 32;
	localparam int PAGE_W = $clog2(PAGE_BYTES);
	localparam int PG_W   = $clog2(NUM_PAGES);
	localparam int SCAN_W = PG_W + 1;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_WEAR_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WEAR_ENABLE    = CFG_IDX_W'(1);

	localparam logic [CTR_W-1:0] THRESHOLD_RESET = CTR_W'(1000);
	localparam logic [CTR_W-1:0] CTR_MAX         = '1;

	// controller to datapath
	typedef struct packed {
		logic load_req;    // capture the request
		logic chunk_step;  // cut next chunk, read its page counter
		logic upd;         // bump page counter and total
		logic emit_chunk;  // send a non-final chunk
		logic scan_init;   // restart max/min scan
		logic scan_run;    // scan one counter a cycle
		logic emit_last;   // send final chunk with wear report
		logic emit_err;    // send range error
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_err;
		logic req_zero;
		logic out_free;
		logic last_chunk;
		logic scan_done;
	} dp_status_t;

	function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
		sat_inc = (v == CTR_MAX) ? v : v + CTR_W'(1);
	endfunction

endpackage

// ===== design/ewswt_ctrl.sv =====
`timescale 1ns / 1ps

module ewswt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  ewswt_pkg::dp_status_t  status_i,
	output ewswt_pkg::ctrl_cmd_t   cmd
);
	import ewswt_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHUNK = 6'b000010,
		ST_EMIT  = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_FIN   = 6'b010000,
		ST_ERR   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					if (status_i.req_err) begin
						state_d = ST_ERR;
					end else if (status_i.req_zero) begin
						cmd.scan_init = 1'b1;
						state_d = ST_SCAN;
					end else begin
						state_d = ST_CHUNK;
					end
				end
			end
			ST_CHUNK: begin
				cmd.chunk_step = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// final chunk waits for the wear scan before it goes out
				if (status_i.last_chunk) begin
					cmd.upd = 1'b1;
					cmd.scan_init = 1'b1;
					state_d = ST_SCAN;
				end else if (status_i.out_free) begin
					cmd.upd = 1'b1;
					cmd.emit_chunk = 1'b1;
					state_d = ST_CHUNK;
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (status_i.scan_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (status_i.out_free) begin
					cmd.emit_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (status_i.out_free) begin
					cmd.emit_err = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/ewswt_dpath.sv =====
`timescale 1ns / 1ps

module ewswt_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ewswt_pkg::ctrl_cmd_t                 cmd,
	output ewswt_pkg::dp_status_t                status_o,
	input  logic [ewswt_pkg::ADDR_W-1:0]         start_addr,
	input  logic [ewswt_pkg::CNT_W-1:0]          byte_count,
	input  logic                                 cfg_valid,
	input  logic [ewswt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ewswt_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 status,
	output logic [ewswt_pkg::ADDR_W-1:0]         chunk_addr,
	output logic [ewswt_pkg::LEN_W-1:0]          chunk_len,
	output logic                                 last,
	output logic                                 wear_alert,
	output logic [ewswt_pkg::CTR_W-1:0]          max_count,
	output logic [ewswt_pkg::CTR_W-1:0]          min_count,
	output logic [ewswt_pkg::CTR_W-1:0]          total_count
);
	import ewswt_pkg::*;

	// configuration
	logic [CTR_W-1:0] thr_q;
	logic             wear_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THRESHOLD_RESET;
			wear_en_q <= 1'b1;
		end else if (cfg_valid) begin
			if (cfg_index == REG_WEAR_THRESHOLD) begin
				thr_q <= cfg_data[CTR_W-1:0];
			end else if (cfg_index == REG_WEAR_ENABLE) begin
				wear_en_q <= cfg_data[0];
			end
		end
	end

	// request walk
	logic [ADDR_W-1:0] cur_addr_q;
	logic [CNT_W-1:0]  remain_q;
	logic [ADDR_W-1:0] pend_addr_q;
	logic [LEN_W-1:0]  pend_len_q;
	logic [LEN_W-1:0]  room;
	logic [LEN_W-1:0]  step_len;
	logic [ADDR_W+1:0] end_addr;

	assign end_addr = {2'b00, start_addr} + {1'b0, byte_count};
	assign room     = LEN_W'(PAGE_BYTES) - LEN_W'(cur_addr_q[PAGE_W-1:0]);
	assign step_len = (remain_q < CNT_W'(room)) ? remain_q[LEN_W-1:0] : room;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			cur_addr_q  <= start_addr;
			remain_q    <= byte_count;
			pend_addr_q <= start_addr;
			pend_len_q  <= '0;
		end else if (cmd.chunk_step) begin
			pend_addr_q <= cur_addr_q;
			pend_len_q  <= step_len;
			cur_addr_q  <= cur_addr_q + ADDR_W'(step_len);
			remain_q    <= remain_q - CNT_W'(step_len);
		end
	end

	// page counter memory, entries read as zero until first written
	logic [CTR_W-1:0]     mem [NUM_PAGES];
	logic [NUM_PAGES-1:0] vld_q;
	logic [SCAN_W-1:0]    scan_idx_q;
	logic                 scan_rd;
	logic                 rd_en;
	logic [PG_W-1:0]      rd_addr;
	logic [PG_W-1:0]      wr_page;
	logic                 wr_en;
	logic [CTR_W-1:0]     rdata_raw_s1;
	logic                 rd_vld_s1;
	logic [CTR_W-1:0]     rdata;
	logic [CTR_W-1:0]     total_q;

	assign scan_rd = cmd.scan_run && (scan_idx_q < SCAN_W'(NUM_PAGES));
	assign rd_en   = cmd.chunk_step || scan_rd;
	assign rd_addr = cmd.chunk_step ? PG_W'(cur_addr_q >> PAGE_W) : scan_idx_q[PG_W-1:0];
	assign wr_page = PG_W'(pend_addr_q >> PAGE_W);
	assign wr_en   = cmd.upd && wear_en_q;
	assign rdata   = rd_vld_s1 ? rdata_raw_s1 : '0;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_page] <= sat_inc(rdata);
		end
		if (rd_en) begin
			rdata_raw_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
			total_q   <= '0;
		end else begin
			if (wr_en) begin
				vld_q[wr_page] <= 1'b1;
				total_q        <= sat_inc(total_q);
			end
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	// max/min scan, one counter a cycle
	logic             scan_pend_s1;
	logic [CTR_W-1:0] max_q;
	logic [CTR_W-1:0] min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			scan_pend_s1 <= 1'b0;
		end else if (cmd.scan_init) begin
			scan_idx_q   <= '0;
			scan_pend_s1 <= 1'b0;
		end else begin
			scan_pend_s1 <= scan_rd;
			if (scan_rd) begin
				scan_idx_q <= scan_idx_q + SCAN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			max_q <= '0;
			min_q <= CTR_MAX;
		end else if (scan_pend_s1) begin
			if (rdata > max_q) begin
				max_q <= rdata;
			end
			if (rdata < min_q) begin
				min_q <= rdata;
			end
		end
	end

	// output register
	logic             out_valid_q;
	logic             status_q;
	logic [ADDR_W-1:0] chunk_addr_q;
	logic [LEN_W-1:0] chunk_len_q;
	logic             last_q;
	logic             alert_q;
	logic [CTR_W-1:0] max_out_q;
	logic [CTR_W-1:0] min_out_q;
	logic [CTR_W-1:0] total_out_q;
	logic [CTR_W-1:0] spread;

	assign spread = max_q - min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_chunk || cmd.emit_last || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_chunk || cmd.emit_last || cmd.emit_err) begin
			status_q     <= cmd.emit_err;
			chunk_addr_q <= cmd.emit_err ? '0 : pend_addr_q;
			chunk_len_q  <= cmd.emit_err ? '0 : pend_len_q;
			last_q       <= cmd.emit_last || cmd.emit_err;
			if (cmd.emit_last && wear_en_q) begin
				alert_q     <= (spread > thr_q);
				max_out_q   <= max_q;
				min_out_q   <= min_q;
				total_out_q <= total_q;
			end else begin
				alert_q     <= 1'b0;
				max_out_q   <= '0;
				min_out_q   <= '0;
				total_out_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign chunk_addr  = chunk_addr_q;
	assign chunk_len   = chunk_len_q;
	assign last        = last_q;
	assign wear_alert  = alert_q;
	assign max_count   = max_out_q;
	assign min_count   = min_out_q;
	assign total_count = total_out_q;

	assign status_o.req_err    = end_addr > (ADDR_W+2)'(DEVICE_BYTES);
	assign status_o.req_zero   = (byte_count == '0);
	assign status_o.out_free   = !out_valid_q || out_ready;
	assign status_o.last_chunk = (remain_q == '0);
	assign status_o.scan_done  = (scan_idx_q == SCAN_W'(NUM_PAGES));

	// a result is only loaded into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_chunk || cmd.emit_last || cmd.emit_err) |-> status_o.out_free)
		else $error("result loaded over a pending result");

	// the final counter read is still being folded in when the scan ends
	a_scan_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_run && status_o.scan_done) |-> scan_pend_s1)
		else $error("scan ended before last counter was compared");

	// a chunk never exceeds one page
	a_len_page: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (chunk_len_q <= LEN_W'(PAGE_BYTES)))
		else $error("chunk longer than a page");

	// an error result carries no wear report
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q) |-> (last_q && max_out_q == '0 && total_out_q == '0))
		else $error("error result carries data");

endmodule

// ===== design/eeprom_write_split_wear_track_unit.sv =====
`timescale 1ns / 1ps

// page-split write planner with per-page wear counters
// input channel (in_valid/in_ready): one request = start_addr, byte_count
// output channel (out_valid/out_ready): one or more results per request, the
//   final one carries last=1 and, when wear tracking is on, the max/min page
//   counts, the total and the wear alert
// config channel (cfg_valid/cfg_ready): index 0 wear_threshold, index 1
//   wear_enable; always ready, write only while no request is in flight
// timing: a request is taken only while the controller is idle; each chunk
//   takes a cut + counter read step, then a counter update step, the wear scan
//   walks all 32 page counters through the single memory read port, one a
//   cycle; a zero-length request runs only the scan, a range error neither
// path: the first chunk leaves through the chunk and emit states into the
//   result register, a range error through the error state into that register
// the result register parts the channels: the next request can be taken while
//   the final result of the previous one still waits on out_ready; a stalled
//   receiver holds back further chunks, nothing is dropped
// reset: counters and total read as zero (per-page valid bits cleared at once),
//   threshold 1000, tracking enabled, output empty
module eeprom_write_split_wear_track_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ewswt_pkg::ADDR_W-1:0]         start_addr,
	input  logic [ewswt_pkg::CNT_W-1:0]          byte_count,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ewswt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ewswt_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 status,
	output logic [ewswt_pkg::ADDR_W-1:0]         chunk_addr,
	output logic [ewswt_pkg::LEN_W-1:0]          chunk_len,
	output logic                                 last,
	output logic                                 wear_alert,
	output logic [ewswt_pkg::CTR_W-1:0]          max_count,
	output logic [ewswt_pkg::CTR_W-1:0]          min_count,
	output logic [ewswt_pkg::CTR_W-1:0]          total_count
);
	import ewswt_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t dp_status;

	// register writes never stall
	assign cfg_ready = 1'b1;

	// sequencer: request walk, counter update, scan, final result
	ewswt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status_i (dp_status),
		.cmd      (cmd)
	);

	// chunk math, counter memory, max/min scan, result register
	ewswt_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status_o    (dp_status),
		.start_addr  (start_addr),
		.byte_count  (byte_count),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.chunk_addr  (chunk_addr),
		.chunk_len   (chunk_len),
		.last        (last),
		.wear_alert  (wear_alert),
		.max_count   (max_count),
		.min_count   (min_count),
		.total_count (total_count)
	);

endmodule

// ===== test/wear_split_monitor.sv =====
`timescale 1ns / 1ps

module wear_split_monitor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [ewswt_pkg::ADDR_W-1:0]     start_addr,
	input  logic [ewswt_pkg::CNT_W-1:0]      byte_count,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [ewswt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ewswt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic                             status,
	input  logic [ewswt_pkg::ADDR_W-1:0]     chunk_addr,
	input  logic [ewswt_pkg::LEN_W-1:0]      chunk_len,
	input  logic                             last,
	input  logic                             wear_alert,
	input  logic [ewswt_pkg::CTR_W-1:0]      max_count,
	input  logic [ewswt_pkg::CTR_W-1:0]      min_count,
	input  logic [ewswt_pkg::CTR_W-1:0]      total_count,
	output int                               mismatches,
	output int                               pending
);
	import ewswt_pkg::*;

	typedef struct packed {
		logic              status;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic              last;
		logic              alert;
		logic [CTR_W-1:0]  max_cnt;
		logic [CTR_W-1:0]  min_cnt;
		logic [CTR_W-1:0]  total;
	} chunk_t;

	logic [CTR_W-1:0] page_wear [NUM_PAGES];
	logic [CTR_W-1:0] pages_total = '0;
	logic [CTR_W-1:0] wear_limit = THRESHOLD_RESET;
	logic             wear_on = 1'b1;
	chunk_t           planned_chunks [$];
	chunk_t           want;

	function automatic logic [CTR_W-1:0] bump(input logic [CTR_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// final chunk carries the spread of the page counters after the update
	function automatic chunk_t add_wear_report(input chunk_t r);
		logic [CTR_W-1:0] hi;
		logic [CTR_W-1:0] lo;
		int p;
		if (!wear_on) begin
			return r;
		end
		hi = '0;
		lo = '1;
		for (p = 0; p < NUM_PAGES; p++) begin
			if (page_wear[p] > hi) hi = page_wear[p];
			if (page_wear[p] < lo) lo = page_wear[p];
		end
		r.alert   = (hi - lo) > wear_limit;
		r.max_cnt = hi;
		r.min_cnt = lo;
		r.total   = pages_total;
		return r;
	endfunction

	// cut one request into page chunks and update the wear counters
	task automatic plan_write(input logic [ADDR_W-1:0] a, input logic [CNT_W-1:0] c);
		chunk_t      plan;
		int unsigned addr;
		int unsigned remain;
		int unsigned room;
		int unsigned n;
		int unsigned page;
		addr = 32'(a);
		remain = 32'(c);
		plan = '0;
		if (addr + remain > DEVICE_BYTES) begin
			plan.status = 1'b1;
			plan.last = 1'b1;
			planned_chunks.push_back(plan);
			return;
		end
		if (remain == 0) begin
			plan.addr = a;
			plan.last = 1'b1;
			planned_chunks.push_back(add_wear_report(plan));
			return;
		end
		while (remain > 0) begin
			room = PAGE_BYTES - (addr % PAGE_BYTES);
			n = (remain < room) ? remain : room;
			page = addr / PAGE_BYTES;
			if (wear_on) begin
				page_wear[page] = bump(page_wear[page]);
				pages_total = bump(pages_total);
			end
			plan = '0;
			plan.addr = ADDR_W'(addr);
			plan.len = LEN_W'(n);
			addr += n;
			remain -= n;
			if (remain == 0) begin
				plan.last = 1'b1;
				plan = add_wear_report(plan);
			end
			planned_chunks.push_back(plan);
		end
	endtask

	task automatic compare_field(input string field, input logic [CTR_W-1:0] exp_v,
			input logic [CTR_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
				exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PAGES; p++) page_wear[p] = '0;
			pages_total = '0;
			wear_limit = THRESHOLD_RESET;
			wear_on = 1'b1;
			planned_chunks.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (planned_chunks.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual addr %0d len %0d",
						$time, chunk_addr, chunk_len);
					mismatches++;
				end else begin
					want = planned_chunks.pop_front();
					compare_field("status", CTR_W'(want.status), CTR_W'(status));
					compare_field("chunk_addr", CTR_W'(want.addr), CTR_W'(chunk_addr));
					compare_field("chunk_len", CTR_W'(want.len), CTR_W'(chunk_len));
					compare_field("last", CTR_W'(want.last), CTR_W'(last));
					compare_field("wear_alert", CTR_W'(want.alert), CTR_W'(wear_alert));
					compare_field("max_count", want.max_cnt, max_count);
					compare_field("min_count", want.min_cnt, min_count);
					compare_field("total_count", want.total, total_count);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_WEAR_THRESHOLD) wear_limit = cfg_data;
				else if (cfg_index == REG_WEAR_ENABLE) wear_on = cfg_data[0];
			end
			if (in_valid && in_ready) begin
				plan_write(start_addr, byte_count);
			end
		end
		pending = planned_chunks.size();
	end

endmodule

// ===== test/tb_eeprom_write_split_wear_track_unit.sv =====
`timescale 1ns / 1ps

module tb_eeprom_write_split_wear_track_unit;
	import ewswt_pkg::*;

	// no handshake at all for this long means the block is hung
	localparam int WATCHDOG_LIMIT = 5000;
	// receiver hold-off, long enough to back the block up into its input
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_TAIL     = 100;
	localparam int IDLE_PERCENT   = 7;
	localparam int SEGMENTS       = 10;
	localparam int SEGMENT_ITEMS  = 25;
	localparam int QUIET_SEGMENT  = 3;
	localparam int DARK_SEGMENT   = 4;
	localparam int HOLD_SEGMENT   = 6;
	localparam int DIRECTED_ITEMS = 17;
	// first index past the register list, writes there must be ignored
	localparam int FIRST_UNUSED_REG = 2;
	localparam int LAST_REG_INDEX   = (1 << CFG_IDX_W) - 1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [ADDR_W-1:0]     start_addr = '0;
	logic [CNT_W-1:0]      byte_count = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  status;
	logic [ADDR_W-1:0]     chunk_addr;
	logic [LEN_W-1:0]      chunk_len;
	logic                  last;
	logic                  wear_alert;
	logic [CTR_W-1:0]      max_count;
	logic [CTR_W-1:0]      min_count;
	logic [CTR_W-1:0]      total_count;

	int mismatches;
	int pending;

	// quiet switches off random idling on both sides, hold_results asks the
	// receiver for one long hold-off
	bit quiet = 1'b0;
	bit hold_results = 1'b0;
	int idle_cycles = 0;

	// directed requests: zero length at both ends, single bytes, chunks inside
	// a page, page crossings, whole pages with no empty tail, the full device,
	// the last byte, and requests running past the end of the device
	int dir_addr [DIRECTED_ITEMS] = '{0, 255, 0, 7, 5, 6, 0, 0, 3, 0, 248, 255, 100,
		1, 255, 0, 128};
	int dir_count [DIRECTED_ITEMS] = '{0, 0, 1, 1, 3, 4, 8, 16, 20, 256, 8, 1, 0,
		256, 2, 511, 300};

	eeprom_write_split_wear_track_unit u_top (.*);

	wear_split_monitor u_monitor (.*);

	always #1 clk = ~clk;

	// watchdog: any accepted request, result or register write restarts it
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stalls, or one long hold-off when asked
	always begin
		@(posedge clk);
		if (hold_results) begin
			out_ready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_results = 1'b0;
		end
		out_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// offer one request, hold it until taken, then maybe leave a gap;
	// valid stays high into the next request when there is no gap
	task automatic send_request(input logic [ADDR_W-1:0] a, input logic [CNT_W-1:0] c);
		in_valid <= 1'b1;
		start_addr <= a;
		byte_count <= c;
		do @(posedge clk); while (!in_ready);
		if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			start_addr <= ADDR_W'($urandom);
			byte_count <= CNT_W'($urandom);
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	// sender pause until every planned chunk has come out, block is idle then
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// register write, valid left high so back-to-back writes need no gap
	task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// mostly well-formed requests of modest size, some long ones, some empty
	// ones and some that run past the device end
	task automatic random_request();
		int unsigned a;
		int unsigned c;
		int unsigned pick;
		int unsigned room;
		a = $urandom_range(DEVICE_BYTES - 1);
		room = DEVICE_BYTES - a;
		pick = $urandom_range(99);
		if (pick < 10) begin
			c = $urandom_range((1 << CNT_W) - 1, room + 1);
		end else if (pick < 18) begin
			c = 0;
		end else if (pick < 28) begin
			c = $urandom_range(room, 1);
		end else begin
			c = $urandom_range((room < 24) ? room : 24, 1);
		end
		send_request(ADDR_W'(a), CNT_W'(c));
	endtask

	initial begin
		int i;
		int seg;
		int unsigned limit;
		// hold reset, then release it at a clock edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part with the reset register values
		for (i = 0; i < DIRECTED_ITEMS; i++) begin
			send_request(ADDR_W'(dir_addr[i]), CNT_W'(dir_count[i]));
		end
		drain();

		// zero threshold: any spread between pages raises the alert
		write_reg(REG_WEAR_THRESHOLD, '0);
		cfg_valid <= 1'b0;
		send_request(ADDR_W'(0), CNT_W'(8));
		send_request(ADDR_W'(8), CNT_W'(0));
		send_request(ADDR_W'(3), CNT_W'(10));
		drain();

		// largest threshold: alert can never fire
		write_reg(REG_WEAR_THRESHOLD, '1);
		cfg_valid <= 1'b0;
		send_request(ADDR_W'(0), CNT_W'(256));
		send_request(ADDR_W'(17), CNT_W'(5));
		drain();

		// tracking off, upper data bits junk; unused indexes get ignored
		write_reg(REG_WEAR_ENABLE, $urandom & ~32'd1);
		write_reg(FIRST_UNUSED_REG, $urandom);
		write_reg(LAST_REG_INDEX, $urandom);
		cfg_valid <= 1'b0;
		send_request(ADDR_W'(0), CNT_W'(40));
		send_request(ADDR_W'(200), CNT_W'(0));
		send_request(ADDR_W'(250), CNT_W'(9));
		send_request(ADDR_W'(33), CNT_W'(7));
		drain();

		// back on, tiny threshold
		write_reg(REG_WEAR_ENABLE, $urandom | 32'd1);
		write_reg(REG_WEAR_THRESHOLD, 32'd1);
		cfg_valid <= 1'b0;
		send_request(ADDR_W'(40), CNT_W'(3));
		send_request(ADDR_W'(0), CNT_W'(0));
		drain();

		// random part, a new register setting for every segment
		for (seg = 0; seg < SEGMENTS; seg++) begin
			drain();
			case (seg)
				0: limit = '0;
				1: limit = '1;
				2: limit = $urandom;
				default: limit = $urandom_range(60);
			endcase
			write_reg(REG_WEAR_THRESHOLD, limit);
			write_reg(REG_WEAR_ENABLE, (seg == DARK_SEGMENT) ? ($urandom & ~32'd1) :
				($urandom | 32'd1));
			if ($urandom_range(1)) begin
				write_reg($urandom_range(LAST_REG_INDEX, FIRST_UNUSED_REG), $urandom);
			end
			cfg_valid <= 1'b0;
			quiet = (seg == QUIET_SEGMENT);
			if (seg == HOLD_SEGMENT) hold_results = 1'b1;
			repeat (SEGMENT_ITEMS) random_request();
		end
		drain();
		quiet = 1'b0;

		// a stray result would still show up in the tail
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
